### sv/jcws_pkg.sv
package jcws_pkg;

    // Characters that steer the scanner.
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // One result item as it waits in the output stage.
    typedef struct packed {
        logic [7:0] clean_byte;
        logic       has_byte;
        logic       run_last;
        logic       doc_done;
        logic       unterminated;
    } res_t;

    // Whitespace outside strings: space and 0x09 to 0x0D.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

### sv/json_comment_whitespace_stripper_unit.sv
// JSON-with-comments stripper and minifier.
//
// The input stream (s_axis_*) carries one document byte per transaction in
// s_axis_tdata, with s_axis_tlast high on the final byte of a document. The
// result stream (m_axis_*) carries the minified text one byte per
// transaction: whitespace and comments outside strings are removed, strings
// pass through untouched. Each input byte gives zero, one or two results;
// m_axis_tuser[1] marks the last result of an input byte, m_axis_tlast marks
// the last result of the document, and m_axis_tuser[2] then reports that the
// document ended inside a string or a block comment. A document end that
// would give no byte gives a bare end marker with m_axis_tuser[0] low.
//
// A byte's first result is on m_axis in the cycle after it is accepted.
// A byte is accepted in every cycle, except that one which releases a held
// slash, if not whitespace, gives two results and blocks input while the
// second result waits in the spill register. When the receiver stalls, the
// results hold on m_axis, and s_axis_tready is low for as long as the output
// slot holds a stalled transaction or the spill register is occupied.
// Reset clears the scan mode to normal text and empties the output.
module json_comment_whitespace_stripper_unit
    import jcws_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // doc_end

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] clean_byte
    output logic [2:0] m_axis_tuser,   // [0] has_byte, [1] run_last, [2] unterminated
    output logic       m_axis_tlast    // doc_done
);

    typedef enum logic [2:0] {
        M_NORMAL     = 3'd0,
        M_SLASH      = 3'd1,
        M_BLOCK      = 3'd2,
        M_BLOCK_STAR = 3'd3,
        M_LINE       = 3'd4,
        M_STRING     = 3'd5,
        M_STRING_ESC = 3'd6
    } mode_t;

    mode_t      mode_reg, mode_next;
    mode_t      mode_scan;
    res_t       out_res_reg, out_res_next;
    res_t       sec_res_reg, sec_res_next;
    logic       out_valid_reg, out_valid_next;
    logic       sec_valid_reg, sec_valid_next;

    logic [7:0] b;
    logic [7:0] byte0, byte1;
    logic [1:0] cnt;
    logic       open_doc;
    logic       accept;
    logic       out_free;
    res_t       r0, r1;

    assign b        = s_axis_tdata;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;

    // The spill register must be empty, and the output slot free, to take
    // a byte: that leaves room for the two results it may cause.
    assign s_axis_tready = !sec_valid_reg && out_free;

    // Scan one byte: the bytes it emits, in order, and the next mode.
    always_comb begin
        byte0     = '0;
        byte1     = '0;
        cnt       = 2'd0;
        mode_scan = mode_reg;
        case (mode_reg)
            M_SLASH: begin
                if (b == CH_STAR) begin
                    mode_scan = M_BLOCK;
                end else if (b == CH_SLASH) begin
                    mode_scan = M_LINE;
                end else begin
                    // The held slash was not a comment opener: release it.
                    byte0     = CH_SLASH;
                    cnt       = 2'd1;
                    mode_scan = M_NORMAL;
                    if (b == CH_QUOTE) begin
                        byte1     = b;
                        cnt       = 2'd2;
                        mode_scan = M_STRING;
                    end else if (!is_ws(b)) begin
                        byte1 = b;
                        cnt   = 2'd2;
                    end
                end
            end
            M_BLOCK: begin
                if (b == CH_STAR) begin
                    mode_scan = M_BLOCK_STAR;
                end
            end
            M_BLOCK_STAR: begin
                if (b == CH_SLASH) begin
                    mode_scan = M_NORMAL;
                end else if (b != CH_STAR) begin
                    mode_scan = M_BLOCK;
                end
            end
            M_LINE: begin
                if (b == CH_NL) begin
                    mode_scan = M_NORMAL;
                end
            end
            M_STRING: begin
                byte0 = b;
                cnt   = 2'd1;
                if (b == CH_BSLASH) begin
                    mode_scan = M_STRING_ESC;
                end else if (b == CH_QUOTE) begin
                    mode_scan = M_NORMAL;
                end
            end
            M_STRING_ESC: begin
                byte0     = b;
                cnt       = 2'd1;
                mode_scan = M_STRING;
            end
            default: begin
                // Normal text, and the unused mode code.
                mode_scan = M_NORMAL;
                if (b == CH_SLASH) begin
                    mode_scan = M_SLASH;
                end else if (!is_ws(b)) begin
                    byte0 = b;
                    cnt   = 2'd1;
                    if (b == CH_QUOTE) begin
                        mode_scan = M_STRING;
                    end
                end
            end
        endcase
    end

    // Build the result items, closing the document where it ends here.
    always_comb begin
        open_doc  = (mode_scan == M_STRING) || (mode_scan == M_STRING_ESC) ||
                    (mode_scan == M_BLOCK)  || (mode_scan == M_BLOCK_STAR);
        r0        = '{clean_byte: byte0, has_byte: (cnt != 2'd0),
                      run_last: 1'b0, doc_done: 1'b0, unterminated: 1'b0};
        r1        = '{clean_byte: byte1, has_byte: 1'b1,
                      run_last: 1'b0, doc_done: 1'b0, unterminated: 1'b0};
        mode_next = mode_scan;
        if (s_axis_tlast) begin
            // A slash held at the end goes out as ordinary text. A scan in
            // slash mode never emitted a byte itself, so it fits in r0.
            if (mode_scan == M_SLASH) begin
                r0.clean_byte = CH_SLASH;
                r0.has_byte   = 1'b1;
            end
            if (cnt == 2'd2) begin
                r1.doc_done     = 1'b1;
                r1.unterminated = open_doc;
            end else begin
                // One byte, or a bare end marker with has_byte low.
                r0.doc_done     = 1'b1;
                r0.unterminated = open_doc;
            end
            mode_next = M_NORMAL;
        end
        if (cnt == 2'd2) begin
            r1.run_last = 1'b1;
        end else begin
            r0.run_last = 1'b1;
        end
    end

    // Output stage and spill register.
    always_comb begin
        out_res_next   = out_res_reg;
        sec_res_next   = sec_res_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        sec_valid_next = sec_valid_reg;
        if (sec_valid_reg) begin
            if (out_free) begin
                out_res_next   = sec_res_reg;
                out_valid_next = 1'b1;
                sec_valid_next = 1'b0;
            end
        end else if (accept) begin
            // A result goes out unless the byte was swallowed mid-document.
            if ((cnt != 2'd0) || s_axis_tlast || (mode_scan == M_SLASH && s_axis_tlast)) begin
                out_res_next   = r0;
                out_valid_next = 1'b1;
            end
            if (cnt == 2'd2) begin
                sec_res_next   = r1;
                sec_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= M_NORMAL;
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg <= mode_next;
            end
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
        out_res_reg <= out_res_next;
        sec_res_reg <= sec_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.clean_byte;
    assign m_axis_tuser  = {out_res_reg.unterminated, out_res_reg.run_last,
                            out_res_reg.has_byte};
    assign m_axis_tlast  = out_res_reg.doc_done;

endmodule

### sv/jcws_checker.sv
module jcws_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result changed");

    // The end of a document also ends the run of its last byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
        else $error("document end without run end");

    // The open-document flag only rides on the document end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast)
        else $error("unterminated flag away from document end");

    // A result without data is only ever the bare end marker, and is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tlast && (m_axis_tdata == 8'h00))
        else $error("empty result that is not an end marker");

endmodule

bind json_comment_whitespace_stripper_unit jcws_checker u_jcws_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
